// ----- hw/rtl/prq_pkg.sv -----
package prq_pkg;

    // Request kinds as carried on the request channel.
    typedef enum logic [1:0] {
        KIND_PUSH   = 2'd0,
        KIND_POP    = 2'd1,
        KIND_PEEK   = 2'd2,
        KIND_DELETE = 2'd3
    } t_kind;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    localparam int KIND_BITS   = 2;
    localparam int STATUS_BITS = 2;
    localparam int OCC_BITS    = 5;

endpackage

// ----- hw/rtl/prq_if.sv -----
// Request channel: one push, pop, peek or delete per transfer.
interface prq_req_if #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
);
    import prq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [KIND_BITS-1:0] kind;
    logic [ID_BITS-1:0]   proc_id;
    logic [PRIO_BITS-1:0] prio;

    modport source (output valid, output kind, output proc_id, output prio, input ready);
    modport sink   (input valid, input kind, input proc_id, input prio, output ready);
endinterface

// Result channel: one result per request.
interface prq_rsp_if #(
    parameter int ID_BITS   = 16,
    parameter int PRIO_BITS = 8
);
    import prq_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    logic [ID_BITS-1:0]     out_id;
    logic [PRIO_BITS-1:0]   out_prio;
    logic [OCC_BITS-1:0]    occupancy;

    modport source (output valid, output status, output out_id, output out_prio,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_prio,
                    input occupancy, output ready);
endinterface

// ----- hw/rtl/prq_ram.sv -----
// Simple dual-port RAM, one write and one registered read per cycle.
module prq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hw/rtl/prq_ctrl.sv -----
// Request sequencer: walks the sorted RAM one entry per cycle.
module prq_ctrl #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    prq_req_if.sink                        i_req,
    prq_rsp_if.source                      o_rsp,
    output logic                           o_we,
    output logic [$clog2(DEPTH)-1:0]       o_waddr,
    output logic [ID_BITS+PRIO_BITS-1:0]   o_wdata,
    output logic [$clog2(DEPTH)-1:0]       o_raddr,
    input  logic [ID_BITS+PRIO_BITS-1:0]   i_rdata
);
    import prq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C  = CW'(1);
    localparam logic [CW-1:0] TWO_C  = CW'(2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_SCAN,
        S_PUSH_HEAD,
        S_HEAD,
        S_SHIFT,
        S_DEL_SCAN,
        S_FIN
    } t_state;

    t_state               r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [ID_BITS-1:0]   r_id, n_id;
    logic [PRIO_BITS-1:0] r_prio, n_prio;
    logic [CW-1:0]        r_k, n_k;
    logic [CW-1:0]        r_count, n_count;
    t_status              r_status, n_status;
    logic [ID_BITS-1:0]   r_oid, n_oid;
    logic [PRIO_BITS-1:0] r_oprio, n_oprio;

    logic                 r_out_valid, n_out_valid;
    t_status              r_out_status, n_out_status;
    logic [ID_BITS-1:0]   r_out_id, n_out_id;
    logic [PRIO_BITS-1:0] r_out_prio, n_out_prio;
    logic [OCC_BITS-1:0]  r_out_occ, n_out_occ;

    logic [ID_BITS-1:0]   w_rd_id;
    logic [PRIO_BITS-1:0] w_rd_prio;
    logic [CW-1:0]        w_km1, w_km2, w_kp1, w_cm1;

    assign w_rd_id   = i_rdata[ID_BITS+PRIO_BITS-1:PRIO_BITS];
    assign w_rd_prio = i_rdata[PRIO_BITS-1:0];
    assign w_km1     = r_k - ONE_C;
    assign w_km2     = r_k - TWO_C;
    assign w_kp1     = r_k + ONE_C;
    assign w_cm1     = r_count - ONE_C;

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.out_id    = r_out_id;
    assign o_rsp.out_prio  = r_out_prio;
    assign o_rsp.occupancy = r_out_occ;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_id         = r_id;
        n_prio       = r_prio;
        n_k          = r_k;
        n_count      = r_count;
        n_status     = r_status;
        n_oid        = r_oid;
        n_oprio      = r_oprio;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_prio   = r_out_prio;
        n_out_occ    = r_out_occ;
        o_we         = 1'b0;
        o_waddr      = '0;
        o_wdata      = {r_id, r_prio};
        o_raddr      = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind   = t_kind'(i_req.kind);
                    n_id     = i_req.proc_id;
                    n_prio   = i_req.prio;
                    n_status = ST_OK;
                    n_oid    = '0;
                    n_oprio  = '0;
                    n_k      = r_count;
                    case (t_kind'(i_req.kind))
                        KIND_PUSH: begin
                            if (r_count == FULL_C) begin
                                n_status = ST_FULL;
                                n_state  = S_FIN;
                            end else if (r_count == '0) begin
                                o_we    = 1'b1;
                                o_wdata = {i_req.proc_id, i_req.prio};
                                n_count = ONE_C;
                                n_state = S_FIN;
                            end else begin
                                o_raddr = w_cm1[AW-1:0];
                                n_state = S_PUSH_SCAN;
                            end
                        end
                        KIND_POP, KIND_PEEK: begin
                            if (r_count == '0) begin
                                n_status = ST_EMPTY;
                                n_state  = S_FIN;
                            end else begin
                                n_state = S_HEAD;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_status = ST_NOT_FOUND;
                                n_state  = S_FIN;
                            end else begin
                                o_raddr = w_cm1[AW-1:0];
                                n_state = S_DEL_SCAN;
                            end
                        end
                    endcase
                end
            end

            // rdata holds entry k-1; move it up or drop the new entry at k
            S_PUSH_SCAN: begin
                o_we    = 1'b1;
                o_waddr = r_k[AW-1:0];
                if (w_rd_prio <= r_prio) begin
                    n_count = r_count + ONE_C;
                    n_state = S_FIN;
                end else begin
                    o_wdata = i_rdata;
                    if (r_k == ONE_C) begin
                        n_state = S_PUSH_HEAD;
                    end else begin
                        o_raddr = w_km2[AW-1:0];
                        n_k     = w_km1;
                    end
                end
            end

            S_PUSH_HEAD: begin
                o_we    = 1'b1;
                n_count = r_count + ONE_C;
                n_state = S_FIN;
            end

            // rdata holds entry 0
            S_HEAD: begin
                n_oid   = w_rd_id;
                n_oprio = w_rd_prio;
                if (r_kind == KIND_PEEK) begin
                    n_state = S_FIN;
                end else if (r_count == ONE_C) begin
                    n_count = '0;
                    n_state = S_FIN;
                end else begin
                    o_raddr = ONE_C[AW-1:0];
                    n_k     = ONE_C;
                    n_state = S_SHIFT;
                end
            end

            // rdata holds entry k; move it down to k-1
            S_SHIFT: begin
                o_we    = 1'b1;
                o_waddr = w_km1[AW-1:0];
                o_wdata = i_rdata;
                if (w_kp1 == r_count) begin
                    n_count = w_cm1;
                    n_state = S_FIN;
                end else begin
                    o_raddr = w_kp1[AW-1:0];
                    n_k     = w_kp1;
                end
            end

            // rdata holds entry k-1; search runs from the tail
            S_DEL_SCAN: begin
                if (w_rd_id == r_id) begin
                    if (r_k == r_count) begin
                        n_count = w_cm1;
                        n_state = S_FIN;
                    end else begin
                        o_raddr = r_k[AW-1:0];
                        n_state = S_SHIFT;
                    end
                end else if (r_k == ONE_C) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_FIN;
                end else begin
                    o_raddr = w_km2[AW-1:0];
                    n_k     = w_km1;
                end
            end

            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_id     = r_oid;
                    n_out_prio   = r_oprio;
                    n_out_occ    = OCC_BITS'(r_count);
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_kind       <= n_kind;
        r_id         <= n_id;
        r_prio       <= n_prio;
        r_k          <= n_k;
        r_status     <= n_status;
        r_oid        <= n_oid;
        r_oprio      <= n_oprio;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_prio   <= n_out_prio;
        r_out_occ    <= n_out_occ;
    end
endmodule

// ----- hw/rtl/priority_ready_queue.sv -----
// Sorted ready queue of (process id, priority) entries, smaller priority first.
// Request channel i_req: kind (push, pop, peek, delete by id), proc_id, prio.
// Result channel o_rsp: status, out_id, out_prio, occupancy; one per request.
// Both channels use valid/ready; a transfer happens when both are high.
// Entries live in one RAM (registered read), kept in order from head to
// tail; equal priorities stay first in, first out.
// A peek reads the head; a pop reads it and then closes the gap; a push scans
// from the tail, moving larger entries up; a delete scans from the tail for
// the id, then closes the gap; refused or empty requests go straight to the result.
// One request is in work at a time; the RAM port visits one entry per cycle
// while a push moves entries toward the tail or a pop/delete closes the gap.
// The result sits in an output register; a new request is taken while it
// waits, and if o_rsp stalls the sequencer holds its next result until the
// register frees up.
// Reset empties the queue and drops any pending result; RAM contents are
// left as they are and only entries below the count are ever read.
module priority_ready_queue #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    prq_req_if.sink   i_req,
    prq_rsp_if.source o_rsp
);
    import prq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int W  = ID_BITS + PRIO_BITS;

    // RAM port between sequencer and storage
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [W-1:0]  w_wdata;
    logic [AW-1:0] w_raddr;
    logic [W-1:0]  w_rdata;

    prq_ctrl #(
        .DEPTH     (DEPTH),
        .PRIO_BITS (PRIO_BITS),
        .ID_BITS   (ID_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .o_we    (w_we),
        .o_waddr (w_waddr),
        .o_wdata (w_wdata),
        .o_raddr (w_raddr),
        .i_rdata (w_rdata)
    );

    prq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Only pop/peek with ok status may carry an entry.
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.out_id == '0 && o_rsp.out_prio == '0))
        else $error("non-ok result carries entry data");

    // Full is reported only with a full queue.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.occupancy == OCC_BITS'(DEPTH)))
        else $error("full status with queue not full");

    // Empty is reported only with an empty queue.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY) |-> (o_rsp.occupancy == '0))
        else $error("empty status with entries held");

    // Writes stay inside the RAM.
    a_waddr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (32'(w_waddr) < DEPTH))
        else $error("RAM write beyond depth");
endmodule

// ----- tb/prq_result_checker.sv -----
// Watches both channels of the ready queue, keeps its own sorted copy of the
// queue and checks every result against the oldest outstanding prediction.
module prq_result_checker #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int ID_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  logic [prq_pkg::KIND_BITS-1:0]   i_req_kind,
    input  logic [ID_BITS-1:0]              i_req_proc_id,
    input  logic [PRIO_BITS-1:0]            i_req_prio,
    input  logic                            i_rsp_valid,
    input  logic                            i_rsp_ready,
    input  logic [prq_pkg::STATUS_BITS-1:0] i_rsp_status,
    input  logic [ID_BITS-1:0]              i_rsp_out_id,
    input  logic [PRIO_BITS-1:0]            i_rsp_out_prio,
    input  logic [prq_pkg::OCC_BITS-1:0]    i_rsp_occupancy,
    output int                              o_fail_count,
    output int                              o_awaiting
);
    import prq_pkg::*;

    typedef struct packed {
        t_status              status;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
        logic [OCC_BITS-1:0]  occ;
    } t_result;

    // Shadow queue, head at slot 0.
    logic [ID_BITS-1:0]   slot_ids   [DEPTH];
    logic [PRIO_BITS-1:0] slot_prios [DEPTH];
    int                   held = 0;

    t_result predicted_results[$];
    int      fail_total = 0;

    function automatic void remove_slot(int pos);
        for (int k = pos; k + 1 < held; k++) begin
            slot_ids[k]   = slot_ids[k + 1];
            slot_prios[k] = slot_prios[k + 1];
        end
        held--;
    endfunction

    function automatic t_result apply_request(t_kind kind, logic [ID_BITS-1:0] id,
                                              logic [PRIO_BITS-1:0] prio);
        t_result r;
        int      pos;
        bit      found;
        r      = '0;
        r.status = ST_OK;
        pos    = 0;
        found  = 1'b0;
        case (kind)
            KIND_PUSH: begin
                if (held >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    // behind every entry of equal or better priority
                    while (pos < held && slot_prios[pos] <= prio) pos++;
                    for (int k = held; k > pos; k--) begin
                        slot_ids[k]   = slot_ids[k - 1];
                        slot_prios[k] = slot_prios[k - 1];
                    end
                    slot_ids[pos]   = id;
                    slot_prios[pos] = prio;
                    held++;
                end
            end
            KIND_POP, KIND_PEEK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.id   = slot_ids[0];
                    r.prio = slot_prios[0];
                    if (kind == KIND_POP) remove_slot(0);
                end
            end
            default: begin
                // the match nearest the tail goes
                for (int k = held - 1; k >= 0 && !found; k--) begin
                    if (slot_ids[k] == id) begin
                        pos   = k;
                        found = 1'b1;
                    end
                end
                if (found) remove_slot(pos);
                else r.status = ST_NOT_FOUND;
            end
        endcase
        r.occ = OCC_BITS'(held);
        return r;
    endfunction

    function automatic void note_failure(string msg);
        fail_total++;
        if (fail_total <= 10) $display("[%0t] prq check: %s", $realtime, msg);
    endfunction

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            held = 0;
            predicted_results.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                got.status = t_status'(i_rsp_status);
                got.id     = i_rsp_out_id;
                got.prio   = i_rsp_out_prio;
                got.occ    = i_rsp_occupancy;
                if (predicted_results.size() == 0) begin
                    note_failure($sformatf("unexpected result: status %0d id %h prio %h occ %0d",
                                           got.status, got.id, got.prio, got.occ));
                end else begin
                    want = predicted_results.pop_front();
                    if (got.status !== want.status || got.id !== want.id ||
                        got.prio !== want.prio || got.occ !== want.occ) begin
                        note_failure($sformatf({"expected status %0d id %h prio %h occ %0d, ",
                                                "got status %0d id %h prio %h occ %0d"},
                                               want.status, want.id, want.prio, want.occ,
                                               got.status, got.id, got.prio, got.occ));
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                predicted_results.push_back(apply_request(t_kind'(i_req_kind),
                                                          i_req_proc_id, i_req_prio));
            end
        end
        o_fail_count <= fail_total;
        o_awaiting   <= predicted_results.size();
    end

endmodule

// ----- tb/tb_priority_ready_queue.sv -----
// Top of the ready queue bench: clock, reset, request stimulus, result-side
// backpressure and the verdict. All checking lives in prq_result_checker.
module tb_priority_ready_queue;
    import prq_pkg::*;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int ID_BITS   = 16;

    // Request mix of a random segment.
    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,   // mostly pushes: runs the queue into full
        MIX_DRAIN   // mostly pops/deletes: runs the queue dry
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    prq_req_if #(.ID_BITS(ID_BITS), .PRIO_BITS(PRIO_BITS)) req_ch ();
    prq_rsp_if #(.ID_BITS(ID_BITS), .PRIO_BITS(PRIO_BITS)) rsp_ch ();

    int fail_count;
    int awaiting;

    // Idle odds in percent, changed per segment.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    // Cycles of forced receiver hold-off still to run.
    int rsp_hold_left  = 0;

    priority_ready_queue #(
        .DEPTH(DEPTH),
        .PRIO_BITS(PRIO_BITS),
        .ID_BITS(ID_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req(req_ch),
        .o_rsp(rsp_ch)
    );

    prq_result_checker #(
        .DEPTH(DEPTH),
        .PRIO_BITS(PRIO_BITS),
        .ID_BITS(ID_BITS)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(req_ch.valid),
        .i_req_ready(req_ch.ready),
        .i_req_kind(req_ch.kind),
        .i_req_proc_id(req_ch.proc_id),
        .i_req_prio(req_ch.prio),
        .i_rsp_valid(rsp_ch.valid),
        .i_rsp_ready(rsp_ch.ready),
        .i_rsp_status(rsp_ch.status),
        .i_rsp_out_id(rsp_ch.out_id),
        .i_rsp_out_prio(rsp_ch.out_prio),
        .i_rsp_occupancy(rsp_ch.occupancy),
        .o_fail_count(fail_count),
        .o_awaiting(awaiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop well past the slowest legal run (worst case is a delete that
    // hits the head of a full queue, with the receiver stalling
    // half the time, plus one long hold-off).
    initial begin
        #4000000;
        $display("priority_ready_queue verification failed");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Present one request and hold it until the block takes it. Valid is only
    // raised here, so it never gets a low and a high in the same step.
    task automatic send_request(t_kind kind, logic [ID_BITS-1:0] id,
                                logic [PRIO_BITS-1:0] prio);
        req_ch.valid   <= 1'b1;
        req_ch.kind    <= kind;
        req_ch.proc_id <= id;
        req_ch.prio    <= prio;
        do @(posedge i_clk); while (!req_ch.ready);
    endtask

    // Optional sender gap after a transfer.
    task automatic sender_gap();
        if ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Sender pause until every outstanding result has come back.
    task automatic wait_all_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
    endtask

    task automatic set_idling(int phase);
        case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
        endcase
    endtask

    // Random request. Ids come mostly from a small pool so that deletes hit
    // and duplicates occur; priorities are often from a tiny range to force
    // ties, otherwise anywhere in the full range.
    task automatic send_random(t_mix mix);
        int                   pick;
        t_kind                kind;
        logic [ID_BITS-1:0]   id;
        logic [PRIO_BITS-1:0] prio;
        pick = $urandom_range(99);
        case (mix)
            MIX_FILL:  kind = pick < 80 ? KIND_PUSH : pick < 88 ? KIND_POP :
                              pick < 94 ? KIND_PEEK : KIND_DELETE;
            MIX_DRAIN: kind = pick < 15 ? KIND_PUSH : pick < 60 ? KIND_POP :
                              pick < 70 ? KIND_PEEK : KIND_DELETE;
            default:   kind = pick < 40 ? KIND_PUSH : pick < 60 ? KIND_POP :
                              pick < 75 ? KIND_PEEK : KIND_DELETE;
        endcase
        id   = ($urandom_range(99) < 70) ? ID_BITS'($urandom_range(15))
                                         : ID_BITS'($urandom_range(65535));
        prio = ($urandom_range(1) == 0) ? PRIO_BITS'($urandom_range(3))
                                        : PRIO_BITS'($urandom_range(255));
        send_request(kind, id, prio);
        sender_gap();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.kind    <= KIND_PUSH;
        req_ch.proc_id <= '0;
        req_ch.prio    <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue cases first.
        send_request(KIND_POP,    16'h0000, 8'h00);
        send_request(KIND_PEEK,   16'hFFFF, 8'hFF);
        send_request(KIND_DELETE, 16'h0042, 8'h00);   // absent id on empty queue
        // Extreme ids and priorities; two entries tie at priority zero.
        send_request(KIND_PUSH,   16'h0000, 8'hFF);
        send_request(KIND_PUSH,   16'hFFFF, 8'h00);
        send_request(KIND_PUSH,   16'hA5A5, 8'h00);
        send_request(KIND_PUSH,   16'h5A5A, 8'hFF);
        send_request(KIND_PEEK,   16'h0000, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);   // oldest of the tie
        send_request(KIND_DELETE, 16'h0000, 8'h00);   // hit
        send_request(KIND_DELETE, 16'hBEEF, 8'h00);   // miss on non-empty queue
        // Duplicate ids: delete must take the one nearest the tail.
        send_request(KIND_PUSH,   16'h0007, 8'd10);
        send_request(KIND_PUSH,   16'h0007, 8'd20);
        send_request(KIND_PUSH,   16'h0007, 8'd10);
        send_request(KIND_DELETE, 16'h0007, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);
        send_request(KIND_POP,    16'h0000, 8'h00);   // empty again
        send_request(KIND_PEEK,   16'h0000, 8'h00);
        wait_all_results();

        // Long receiver hold-off while the sender keeps pushing: the output
        // register and the sequencer fill, and the request side must stall.
        rsp_hold_left = 400;
        for (int n = 0; n < 40; n++) send_random(MIX_FILL);
        wait_all_results();

        // Random segments, rotating through the idling phases.
        for (int round = 0; round < 7; round++) begin
            for (int phase = 0; phase < 4; phase++) begin
                t_mix mix;
                set_idling(phase);
                mix = t_mix'($urandom_range(2));
                for (int n = 0; n < 60; n++) send_random(mix);
                if ($urandom_range(1) == 0) wait_all_results();
            end
        end

        // Let the tail drain, then give stray results a chance to show up.
        wait_all_results();
        repeat (40) @(posedge i_clk);

        if (fail_count == 0 && awaiting == 0) begin
            $display("priority_ready_queue verification clean");
        end else begin
            $display("priority_ready_queue verification failed");
        end
        $finish;
    end

endmodule
